// File: rtl/sdspi_pkg.sv
// Shared constants, types and register map functions for the sigma-delta ADC SPI register slave.
package sdspi_pkg;

    localparam int NUM_REGS   = 57;
    localparam int ADDR_W     = 6;
    localparam int REG_W      = 24;
    localparam int SHIFT_W    = 32;
    localparam int CHAN_W     = 4;
    localparam int CTRL_W     = 16;

    localparam int CHANNEL_REGS_DEF = 16;
    localparam int SETUP_REGS_DEF   = 8;

    // Register addresses.
    localparam logic [ADDR_W-1:0] ADDR_STATUS = 6'h00;
    localparam logic [ADDR_W-1:0] ADDR_CTRL   = 6'h01;
    localparam logic [ADDR_W-1:0] ADDR_DATA   = 6'h02;
    localparam logic [ADDR_W-1:0] ADDR_IOCON1 = 6'h03;
    localparam logic [ADDR_W-1:0] ADDR_IOCON2 = 6'h04;
    localparam logic [ADDR_W-1:0] ADDR_ID     = 6'h05;
    localparam logic [ADDR_W-1:0] ADDR_ERROR  = 6'h06;
    localparam logic [ADDR_W-1:0] ADDR_ERR_EN = 6'h07;
    localparam logic [ADDR_W-1:0] ADDR_MCLK   = 6'h08;
    localparam logic [ADDR_W-1:0] ADDR_CH0    = 6'h09;
    localparam logic [ADDR_W-1:0] ADDR_CFG0   = 6'h19;
    localparam logic [ADDR_W-1:0] ADDR_FILT0  = 6'h21;
    localparam logic [ADDR_W-1:0] ADDR_OFFS0  = 6'h29;
    localparam logic [ADDR_W-1:0] ADDR_GAIN0  = 6'h31;
    localparam logic [ADDR_W-1:0] ADDR_END    = 6'h39;

    // Reset values.
    localparam logic [REG_W-1:0] DEF_ID     = 24'h000002;
    localparam logic [REG_W-1:0] DEF_ERR_EN = 24'h000040;
    localparam logic [REG_W-1:0] DEF_CH0    = 24'h008001;
    localparam logic [REG_W-1:0] DEF_CH     = 24'h000001;
    localparam logic [REG_W-1:0] DEF_CFG    = 24'h000860;
    localparam logic [REG_W-1:0] DEF_FILT   = 24'h060180;
    localparam logic [REG_W-1:0] DEF_OFFS   = 24'h800000;
    localparam logic [REG_W-1:0] DEF_GAIN   = 24'h500000;

    localparam int CTRL_DATA_STATUS_BIT = 10;
    localparam logic [7:0] RESET_BYTE   = 8'hFF;

    // Transfer phases.
    localparam logic [1:0] PH_IDLE  = 2'd0;
    localparam logic [1:0] PH_READ  = 2'd1;
    localparam logic [1:0] PH_WRITE = 2'd2;

    // Item kinds.
    localparam logic OP_SPI  = 1'b0;
    localparam logic OP_CONV = 1'b1;

    typedef struct packed {
        logic capture;
        logic execute;
    } sdspi_cmd_t;

    function automatic logic [2:0] reg_size(input logic [ADDR_W-1:0] a);
        logic [2:0] sz;
        unique case (a)
            ADDR_STATUS, ADDR_ID, ADDR_MCLK:                    sz = 3'd1;
            ADDR_CTRL, ADDR_IOCON2:                             sz = 3'd2;
            ADDR_DATA, ADDR_IOCON1, ADDR_ERROR, ADDR_ERR_EN:    sz = 3'd3;
            default:                                            sz = (a < ADDR_FILT0) ? 3'd2 : 3'd3;
        endcase
        return sz;
    endfunction

    function automatic logic reg_read_only(input logic [ADDR_W-1:0] a);
        return (a == ADDR_STATUS) || (a == ADDR_DATA) || (a == ADDR_ID) ||
               (a == ADDR_ERROR) || (a == ADDR_MCLK);
    endfunction

    function automatic logic [REG_W-1:0] reg_default(input logic [ADDR_W-1:0] a);
        logic [REG_W-1:0] v;
        v = '0;
        if (a == ADDR_ID)                            v = DEF_ID;
        else if (a == ADDR_ERR_EN)                   v = DEF_ERR_EN;
        else if (a == ADDR_CH0)                      v = DEF_CH0;
        else if (a > ADDR_CH0 && a < ADDR_CFG0)      v = DEF_CH;
        else if (a >= ADDR_CFG0 && a < ADDR_FILT0)   v = DEF_CFG;
        else if (a >= ADDR_FILT0 && a < ADDR_OFFS0)  v = DEF_FILT;
        else if (a >= ADDR_OFFS0 && a < ADDR_GAIN0)  v = DEF_OFFS;
        else if (a >= ADDR_GAIN0 && a < ADDR_END)    v = DEF_GAIN;
        return v;
    endfunction

endpackage

// File: rtl/sdspi_ctrl.sv
// Item controller: sequences the capture and execute cycles of each transfer and strobes results.
module sdspi_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    output logic                done,
    output sdspi_pkg::sdspi_cmd_t cmd
);
    import sdspi_pkg::*;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    logic state_reg;
    logic state_next;
    logic done_reg;
    logic done_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        done_next = (state_reg == ST_EXEC);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    assign busy        = (state_reg == ST_EXEC);
    assign done        = done_reg;
    assign cmd.capture = start && (state_reg == ST_IDLE);
    assign cmd.execute = (state_reg == ST_EXEC);

endmodule

// File: rtl/sdspi_datapath.sv
// Datapath: register map storage, transfer state, reset-sequence counter and result registers.
module sdspi_datapath #(
    parameter int CHANNEL_REGS = sdspi_pkg::CHANNEL_REGS_DEF,
    parameter int SETUP_REGS   = sdspi_pkg::SETUP_REGS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  sdspi_pkg::sdspi_cmd_t cmd,
    input  logic                  opcode,
    input  logic [7:0]            mosi_byte,
    input  logic [23:0]           conv_data,
    input  logic [3:0]            conv_channel,
    output logic [7:0]            miso_byte,
    output logic                  rdy_n,
    output logic                  por_status,
    output logic                  reset_seen,
    output logic                  cmd_ignored
);
    import sdspi_pkg::*;

    // Captured item.
    logic              op_reg;
    logic [7:0]        mosi_reg;
    logic [REG_W-1:0]  cdata_reg;
    logic [CHAN_W-1:0] cchan_reg;

    // Register map: status, control and data live in flops, the rest in memory.
    logic [REG_W-1:0]  mem [NUM_REGS];
    logic [REG_W-1:0]  rd_data_reg;
    logic [NUM_REGS-1:0] valid_reg, valid_next;
    logic [CHAN_W-1:0] chan_reg, chan_next;
    logic [CTRL_W-1:0] ctrl_reg, ctrl_next;
    logic [REG_W-1:0]  data_reg, data_next;

    // Transfer state.
    logic [1:0]         phase_reg, phase_next;
    logic [ADDR_W-1:0]  addr_reg, addr_next;
    logic [2:0]         left_reg, left_next;
    logic [SHIFT_W-1:0] shift_reg, shift_next;
    logic [2:0]         ones_reg, ones_next;
    logic               rdy_reg, rdy_next;
    logic               por_reg, por_next;

    // Results.
    logic [7:0] miso_reg, miso_next;
    logic       rdy_o_reg, por_o_reg;
    logic       rs_reg, rs_next;
    logic       ign_reg, ign_next;

    // Memory write port.
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [REG_W-1:0]  mem_wdata;

    logic [ADDR_W-1:0] cmd_addr;
    logic              cmd_valid;
    logic [REG_W-1:0]  stored_val;
    logic [7:0]        status_byte;
    logic [SHIFT_W-1:0] shifted_in;
    logic [REG_W-1:0]  commit_val;
    logic [2:0]        left_dec;

    assign cmd_addr    = mosi_reg[ADDR_W-1:0];
    assign status_byte = {rdy_reg, 2'b00, por_reg, chan_reg};

    always_comb
    begin
        if (cmd_addr >= ADDR_CH0 && cmd_addr < ADDR_CFG0)
        begin
            cmd_valid = (int'(cmd_addr) - int'(ADDR_CH0)) < CHANNEL_REGS;
        end
        else if (cmd_addr >= ADDR_CFG0 && cmd_addr < ADDR_END)
        begin
            cmd_valid = int'(3'(cmd_addr - ADDR_CFG0)) < SETUP_REGS;
        end
        else
        begin
            cmd_valid = (cmd_addr < ADDR_CH0);
        end
    end

    always_comb
    begin
        stored_val = '0;
        if (cmd_addr == ADDR_CTRL)
        begin
            stored_val = {{(REG_W-CTRL_W){1'b0}}, ctrl_reg};
        end
        else if (int'(cmd_addr) < NUM_REGS)
        begin
            stored_val = valid_reg[cmd_addr] ? rd_data_reg : reg_default(cmd_addr);
        end
    end

    assign shifted_in = {shift_reg[SHIFT_W-9:0], mosi_reg};

    always_comb
    begin
        case (reg_size(addr_reg))
            3'd1:    commit_val = {16'h0000, shifted_in[7:0]};
            3'd2:    commit_val = {8'h00, shifted_in[15:0]};
            default: commit_val = shifted_in[REG_W-1:0];
        endcase
    end

    assign left_dec = (left_reg != 3'd0) ? (left_reg - 3'd1) : 3'd0;

    always_comb
    begin
        valid_next = valid_reg;
        chan_next  = chan_reg;
        ctrl_next  = ctrl_reg;
        data_next  = data_reg;
        phase_next = phase_reg;
        addr_next  = addr_reg;
        left_next  = left_reg;
        shift_next = shift_reg;
        ones_next  = ones_reg;
        rdy_next   = rdy_reg;
        por_next   = por_reg;
        miso_next  = 8'h00;
        rs_next    = 1'b0;
        ign_next   = 1'b0;
        mem_we     = 1'b0;
        mem_waddr  = addr_reg;
        mem_wdata  = commit_val;

        if (op_reg == OP_CONV)
        begin
            data_next = cdata_reg;
            chan_next = cchan_reg;
            rdy_next  = 1'b0;
        end
        else
        begin
            case (phase_reg)
                PH_READ:
                begin
                    if (left_reg == 3'd0 || left_reg > 3'd4)
                    begin
                        phase_next = PH_IDLE;
                        left_next  = 3'd0;
                    end
                    else
                    begin
                        case (left_reg)
                            3'd1:    miso_next = shift_reg[7:0];
                            3'd2:    miso_next = shift_reg[15:8];
                            3'd3:    miso_next = shift_reg[23:16];
                            default: miso_next = shift_reg[31:24];
                        endcase
                        left_next = left_reg - 3'd1;
                        if (left_reg == 3'd1)
                        begin
                            phase_next = PH_IDLE;
                        end
                    end
                end
                PH_WRITE:
                begin
                    shift_next = shifted_in;
                    left_next  = left_dec;
                    if (left_dec == 3'd0)
                    begin
                        if (!reg_read_only(addr_reg) && int'(addr_reg) < NUM_REGS)
                        begin
                            if (addr_reg == ADDR_CTRL)
                            begin
                                ctrl_next = commit_val[CTRL_W-1:0];
                            end
                            else
                            begin
                                mem_we = 1'b1;
                                valid_next[addr_reg] = 1'b1;
                            end
                        end
                        phase_next = PH_IDLE;
                    end
                end
                default:
                begin
                    if (mosi_reg[7] || !cmd_valid)
                    begin
                        ign_next   = 1'b1;
                        phase_next = PH_IDLE;
                    end
                    else
                    begin
                        addr_next  = cmd_addr;
                        left_next  = reg_size(cmd_addr);
                        shift_next = '0;
                        if (mosi_reg[6])
                        begin
                            if (cmd_addr == ADDR_STATUS)
                            begin
                                shift_next = {24'h000000, status_byte};
                                por_next   = 1'b0;
                            end
                            else if (cmd_addr == ADDR_DATA)
                            begin
                                if (ctrl_reg[CTRL_DATA_STATUS_BIT])
                                begin
                                    shift_next = {data_reg, status_byte};
                                    left_next  = 3'd4;
                                end
                                else
                                begin
                                    shift_next = {8'h00, data_reg};
                                end
                                rdy_next = 1'b1;
                            end
                            else
                            begin
                                shift_next = {8'h00, stored_val};
                            end
                            phase_next = PH_READ;
                        end
                        else
                        begin
                            phase_next = PH_WRITE;
                        end
                    end
                end
            endcase

            // Sixty-four consecutive ones restore the whole register map.
            if (mosi_reg == RESET_BYTE)
            begin
                if (ones_reg == 3'd7)
                begin
                    valid_next = '0;
                    chan_next  = '0;
                    ctrl_next  = '0;
                    data_next  = '0;
                    phase_next = PH_IDLE;
                    addr_next  = '0;
                    left_next  = '0;
                    shift_next = '0;
                    rdy_next   = 1'b1;
                    por_next   = 1'b1;
                    ones_next  = '0;
                    rs_next    = 1'b1;
                end
                else
                begin
                    ones_next = ones_reg + 3'd1;
                end
            end
            else
            begin
                ones_next = '0;
            end
        end
    end

    // Item capture and memory read.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg    <= opcode;
            mosi_reg  <= mosi_byte;
            cdata_reg <= conv_data;
            cchan_reg <= conv_channel;
            if (int'(mosi_byte[ADDR_W-1:0]) < NUM_REGS)
            begin
                rd_data_reg <= mem[mosi_byte[ADDR_W-1:0]];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.execute && mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            chan_reg  <= '0;
            ctrl_reg  <= '0;
            data_reg  <= '0;
            phase_reg <= PH_IDLE;
            addr_reg  <= '0;
            left_reg  <= '0;
            shift_reg <= '0;
            ones_reg  <= '0;
            rdy_reg   <= 1'b1;
            por_reg   <= 1'b1;
        end
        else if (cmd.execute)
        begin
            valid_reg <= valid_next;
            chan_reg  <= chan_next;
            ctrl_reg  <= ctrl_next;
            data_reg  <= data_next;
            phase_reg <= phase_next;
            addr_reg  <= addr_next;
            left_reg  <= left_next;
            shift_reg <= shift_next;
            ones_reg  <= ones_next;
            rdy_reg   <= rdy_next;
            por_reg   <= por_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.execute)
        begin
            miso_reg  <= miso_next;
            rdy_o_reg <= rdy_next;
            por_o_reg <= por_next;
            rs_reg    <= rs_next;
            ign_reg   <= ign_next;
        end
    end

    assign miso_byte   = miso_reg;
    assign rdy_n       = rdy_o_reg;
    assign por_status  = por_o_reg;
    assign reset_seen  = rs_reg;
    assign cmd_ignored = ign_reg;

endmodule

// File: rtl/sigma_delta_adc_spi_register_slave.sv
// Top level of the sigma-delta ADC SPI register slave.
//
// The block models the device side of the converter's byte-level register port.
// An input transfer is accepted at a rising clock edge where start is high and busy
// is low. opcode selects the item: zero carries one SPI byte in mosi_byte, one carries
// a conversion-complete event with conv_data and conv_channel.
// Every accepted item yields exactly one result. The controller enters its execute
// state, and the result registers behind miso_byte, rdy_n, por_status, reset_seen and
// cmd_ignored load at the end of it; done marks the result for one cycle. The
// receiver cannot stall, so results are never held.
// Busy is high while the controller is in its execute state, so the block cannot take a new
// item until the last one has executed. The execute state is needed because the
// register map memory registers its read data when the command byte is captured.
// At reset the controller is idle, the transfer state clears, RDY and POR are set,
// and every register reads its default value. Eight consecutive 0xFF bytes restore
// the same state at once; no clearing pass is needed because per-entry valid bits
// select the default value for entries not written since the last restore.
// CHANNEL_REGS and SETUP_REGS set how many channel and setup registers respond.
module sigma_delta_adc_spi_register_slave #(
    parameter int CHANNEL_REGS = sdspi_pkg::CHANNEL_REGS_DEF,
    parameter int SETUP_REGS   = sdspi_pkg::SETUP_REGS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        opcode,
    input  logic [7:0]  mosi_byte,
    input  logic [23:0] conv_data,
    input  logic [3:0]  conv_channel,
    output logic        done,
    output logic [7:0]  miso_byte,
    output logic        rdy_n,
    output logic        por_status,
    output logic        reset_seen,
    output logic        cmd_ignored
);
    import sdspi_pkg::*;

    // Commands from the controller to the datapath.
    sdspi_cmd_t cmd;

    // The controller accepts a transfer and runs the execute cycle.
    sdspi_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .cmd   (cmd)
    );

    // The datapath holds the register map and all transfer state.
    sdspi_datapath #(
        .CHANNEL_REGS (CHANNEL_REGS),
        .SETUP_REGS   (SETUP_REGS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .opcode       (opcode),
        .mosi_byte    (mosi_byte),
        .conv_data    (conv_data),
        .conv_channel (conv_channel),
        .miso_byte    (miso_byte),
        .rdy_n        (rdy_n),
        .por_status   (por_status),
        .reset_seen   (reset_seen),
        .cmd_ignored  (cmd_ignored)
    );

endmodule

// File: rtl/sdspi_checker.sv
// Port-level checker for the SPI register slave, bound to the top level.
module sdspi_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic        opcode,
    input logic        done,
    input logic [7:0]  miso_byte,
    input logic        rdy_n,
    input logic        por_status,
    input logic        reset_seen,
    input logic        cmd_ignored
);

    // Each accepted transfer is followed by its result strobe on done.
    a_result_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##2 done)
        else $error("result strobe missing two cycles after acceptance");

    // Results never come back to back, since the block is busy while it executes an item.
    a_no_double_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe held longer than one cycle");

    // A completed reset sequence leaves RDY and POR both set.
    a_reset_flags: assert property (@(posedge clk) disable iff (!rst_n)
        (done && reset_seen) |-> (rdy_n && por_status))
        else $error("reset sequence did not set RDY and POR");

    // An ignored command byte shifts nothing out.
    a_ignored_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (done && cmd_ignored) |-> (miso_byte == 8'h00))
        else $error("ignored command produced read data");

    // A conversion event clears RDY in its own result.
    a_event_rdy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && opcode) |-> ##2 !rdy_n)
        else $error("conversion event did not clear RDY");

endmodule

bind sigma_delta_adc_spi_register_slave sdspi_checker u_sdspi_checker (.*);

// File: sim/sdspi_reply_checker.sv
// Checker that predicts every reply of the SPI register slave and compares it field by field.
module sdspi_reply_checker #(
    parameter int CHANNEL_REGS = sdspi_pkg::CHANNEL_REGS_DEF,
    parameter int SETUP_REGS   = sdspi_pkg::SETUP_REGS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic        opcode,
    input  logic [7:0]  mosi_byte,
    input  logic [23:0] conv_data,
    input  logic [3:0]  conv_channel,
    input  logic        done,
    input  logic [7:0]  miso_byte,
    input  logic        rdy_n,
    input  logic        por_status,
    input  logic        reset_seen,
    input  logic        cmd_ignored,
    output int          fail_count,
    output int          outstanding,
    output int          replies_checked,
    output int          restores_seen
);
    import sdspi_pkg::*;

    typedef struct packed {
        logic [7:0] miso;
        logic       rdy_n;
        logic       por;
        logic       reset_seen;
        logic       ignored;
    } reply_t;

    // Shadow copy of the device state.
    logic [REG_W-1:0]   regfile [NUM_REGS];
    logic [1:0]         phase;
    logic [ADDR_W-1:0]  cur_addr;
    logic [2:0]         left;
    logic [SHIFT_W-1:0] shifter;
    logic [2:0]         ones_run;
    logic               rdy;
    logic               por;

    reply_t pending_replies [$];
    reply_t want_reply;
    reply_t got_reply;
    int     errors;

    assign fail_count = errors;

    initial
    begin
        errors          = 0;
        replies_checked = 0;
        restores_seen   = 0;
        outstanding     = 0;
    end

    function automatic logic [2:0] byte_count(input logic [ADDR_W-1:0] a);
        case (a)
            ADDR_STATUS, ADDR_ID, ADDR_MCLK:                 return 3'd1;
            ADDR_CTRL, ADDR_IOCON2:                          return 3'd2;
            ADDR_DATA, ADDR_IOCON1, ADDR_ERROR, ADDR_ERR_EN: return 3'd3;
            default:
            begin
                if (a >= ADDR_FILT0)
                    return 3'd3;
                return 3'd2;
            end
        endcase
    endfunction

    function automatic logic writable(input logic [ADDR_W-1:0] a);
        return !(a inside {ADDR_STATUS, ADDR_DATA, ADDR_ID, ADDR_ERROR, ADDR_MCLK});
    endfunction

    function automatic logic responds(input logic [ADDR_W-1:0] a);
        if (a < ADDR_CH0)
            return 1'b1;
        if (a < ADDR_CFG0)
            return int'(a - ADDR_CH0) < CHANNEL_REGS;
        if (a < ADDR_END)
            return int'((a - ADDR_CFG0) & 6'd7) < SETUP_REGS;
        return 1'b0;
    endfunction

    function automatic logic [REG_W-1:0] power_on_value(input logic [ADDR_W-1:0] a);
        if (a == ADDR_ID)     return DEF_ID;
        if (a == ADDR_ERR_EN) return DEF_ERR_EN;
        if (a == ADDR_CH0)    return DEF_CH0;
        if (a > ADDR_CH0 && a < ADDR_CFG0)    return DEF_CH;
        if (a >= ADDR_CFG0 && a < ADDR_FILT0) return DEF_CFG;
        if (a >= ADDR_FILT0 && a < ADDR_OFFS0) return DEF_FILT;
        if (a >= ADDR_OFFS0 && a < ADDR_GAIN0) return DEF_OFFS;
        if (a >= ADDR_GAIN0 && a < ADDR_END)  return DEF_GAIN;
        return '0;
    endfunction

    function automatic logic [7:0] status_value();
        return {rdy, 2'b00, por, regfile[ADDR_STATUS][3:0]};
    endfunction

    // Everything but the run of ones goes back to its power-on value.
    task automatic restore_regmap();
        for (int i = 0; i < NUM_REGS; i++)
            regfile[i] = power_on_value(ADDR_W'(i));
        phase    = PH_IDLE;
        cur_addr = '0;
        left     = '0;
        shifter  = '0;
        rdy      = 1'b1;
        por      = 1'b1;
    endtask

    task automatic advance_regmap(input logic op, input logic [7:0] b,
                                  input logic [23:0] cd, input logic [3:0] ch,
                                  output reply_t r);
        logic [ADDR_W-1:0] a;
        logic [2:0]        n;
        logic [REG_W-1:0]  keep;
        r = '0;
        if (op == OP_CONV)
        begin
            regfile[ADDR_DATA]   = cd;
            regfile[ADDR_STATUS] = {20'd0, ch};
            rdy = 1'b0;
        end
        else
        begin
            case (phase)
                PH_READ:
                begin
                    n = left;
                    if (n == 3'd0 || n > 3'd4)
                    begin
                        phase = PH_IDLE;
                        left  = '0;
                    end
                    else
                    begin
                        r.miso = 8'(shifter >> (8 * (int'(n) - 1)));
                        left   = n - 3'd1;
                        if (left == 3'd0)
                            phase = PH_IDLE;
                    end
                end
                PH_WRITE:
                begin
                    shifter = {shifter[SHIFT_W-9:0], b};
                    if (left != 3'd0)
                        left = left - 3'd1;
                    if (left == 3'd0)
                    begin
                        case (byte_count(cur_addr))
                            3'd1:    keep = 24'h0000FF;
                            3'd2:    keep = 24'h00FFFF;
                            default: keep = 24'hFFFFFF;
                        endcase
                        if (writable(cur_addr))
                            regfile[cur_addr] = shifter[REG_W-1:0] & keep;
                        phase = PH_IDLE;
                    end
                end
                default:
                begin
                    a = b[ADDR_W-1:0];
                    if (b[7] || !responds(a))
                    begin
                        r.ignored = 1'b1;
                        phase     = PH_IDLE;
                    end
                    else
                    begin
                        cur_addr = a;
                        left     = byte_count(a);
                        shifter  = '0;
                        if (b[6])
                        begin
                            // The streamed value is captured before RDY or POR change.
                            if (a == ADDR_STATUS)
                            begin
                                shifter = {24'd0, status_value()};
                                por     = 1'b0;
                            end
                            else if (a == ADDR_DATA)
                            begin
                                shifter = {8'd0, regfile[ADDR_DATA]};
                                if (regfile[ADDR_CTRL][CTRL_DATA_STATUS_BIT])
                                begin
                                    shifter = {regfile[ADDR_DATA], status_value()};
                                    left    = 3'd4;
                                end
                                rdy = 1'b1;
                            end
                            else
                            begin
                                shifter = {8'd0, regfile[a]};
                            end
                            phase = PH_READ;
                        end
                        else
                        begin
                            phase = PH_WRITE;
                        end
                    end
                end
            endcase

            // The eighth 0xFF in a row is handled as a normal byte first, then restores.
            if (b == RESET_BYTE)
            begin
                if (ones_run >= 3'd7)
                begin
                    restore_regmap();
                    ones_run     = '0;
                    r.reset_seen = 1'b1;
                    restores_seen++;
                end
                else
                begin
                    ones_run = ones_run + 3'd1;
                end
            end
            else
            begin
                ones_run = '0;
            end
        end
        r.rdy_n = rdy;
        r.por   = por;
    endtask

    // Every mismatch prints one line and is counted.
    task automatic flag_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        errors++;
        $display("MISMATCH %0t: %s is %0h, predicted %0h", $time, what, got, want);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            restore_regmap();
            ones_run = '0;
            pending_replies.delete();
            outstanding <= 0;
        end
        else
        begin
            if (start === 1'b1 && busy === 1'b0)
            begin
                advance_regmap(opcode, mosi_byte, conv_data, conv_channel, want_reply);
                pending_replies.push_back(want_reply);
            end
            if (done === 1'b1)
            begin
                got_reply = {miso_byte, rdy_n, por_status, reset_seen, cmd_ignored};
                if (pending_replies.size() == 0)
                begin
                    flag_mismatch("reply with no transfer outstanding", 32'(got_reply),
                                  32'd0);
                end
                else
                begin
                    want_reply = pending_replies.pop_front();
                    replies_checked++;
                    if (got_reply.miso !== want_reply.miso)
                        flag_mismatch("miso_byte", 32'(got_reply.miso),
                                      32'(want_reply.miso));
                    if (got_reply.rdy_n !== want_reply.rdy_n)
                        flag_mismatch("rdy_n", 32'(got_reply.rdy_n),
                                      32'(want_reply.rdy_n));
                    if (got_reply.por !== want_reply.por)
                        flag_mismatch("por_status", 32'(got_reply.por),
                                      32'(want_reply.por));
                    if (got_reply.reset_seen !== want_reply.reset_seen)
                        flag_mismatch("reset_seen", 32'(got_reply.reset_seen),
                                      32'(want_reply.reset_seen));
                    if (got_reply.ignored !== want_reply.ignored)
                        flag_mismatch("cmd_ignored", 32'(got_reply.ignored),
                                      32'(want_reply.ignored));
                end
            end
            outstanding <= pending_replies.size();
        end
    end

endmodule

// File: sim/sigma_delta_adc_spi_register_slave_tb.sv
// Testbench top for the SPI register slave: stimulus, idling, timeout and verdict.
module sigma_delta_adc_spi_register_slave_tb;

    import sdspi_pkg::*;

    // Number of random items after the directed opening.
    localparam int RANDOM_ITEMS = 1850;
    // Generous ceiling on the whole run.
    localparam int CYCLE_LIMIT  = 200000;
    // Cycles allowed after the last reply before the verdict.
    localparam int SETTLE       = 8;

    // Fields of a command byte.
    localparam logic CMD_RD = 1'b1;
    localparam logic CMD_WR = 1'b0;
    localparam logic WEN    = 1'b1;

    logic        clk          = 1'b0;
    logic        rst_n        = 1'b0;
    logic        start        = 1'b0;
    logic        opcode       = OP_SPI;
    logic [7:0]  mosi_byte    = '0;
    logic [23:0] conv_data    = '0;
    logic [3:0]  conv_channel = '0;
    logic        busy;
    logic        done;
    logic [7:0]  miso_byte;
    logic        rdy_n;
    logic        por_status;
    logic        reset_seen;
    logic        cmd_ignored;

    int fail_count;
    int outstanding;
    int replies_checked;
    int restores_seen;

    // Percentage of items preceded by idle cycles on the sending side.
    int idle_pct     = 0;
    int items_sent   = 0;
    int transactions = 0;
    int conv_events  = 0;
    int cycle_count  = 0;

    sigma_delta_adc_spi_register_slave i_dut (.*);

    // The checker sits beside the block, watching both channels and predicting replies.
    sdspi_reply_checker i_checker (.*);

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Watchdog: a hung handshake or a lost reply ends the run here.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles with %0d replies outstanding.",
                     cycle_count, outstanding);
            $display("simulation failed");
            $finish;
        end
    end

    // One transfer into the block. Random idle cycles come first, so gaps land
    // between any two bytes of a register access, not only between accesses.
    // Start stays high from one transfer to the next when there is no gap, and
    // the transfer completes at the first edge where busy is low.
    task automatic transfer_item(input logic op, input logic [7:0] b,
                                 input logic [23:0] cd, input logic [3:0] ch);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start        <= 1'b1;
        opcode       <= op;
        mosi_byte    <= b;
        conv_data    <= cd;
        conv_channel <= ch;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        items_sent++;
    endtask

    // SPI bytes carry random conversion fields, and conversion events carry a
    // random byte, so the block must ignore the unused fields of each kind.
    task automatic spi_byte(input logic [7:0] b);
        transfer_item(OP_SPI, b, 24'($urandom), 4'($urandom));
    endtask

    task automatic conv_event(input logic [23:0] cd, input logic [3:0] ch);
        conv_events++;
        transfer_item(OP_CONV, 8'($urandom), cd, ch);
    endtask

    // Command byte followed by exactly the register's bytes, MSB first.
    task automatic write_register(input logic [ADDR_W-1:0] a, input logic [23:0] value);
        int n;
        n = int'(reg_size(a));
        transactions++;
        spi_byte({WEN ^ 1'b1, CMD_WR, a});
        for (int k = n - 1; k >= 0; k--)
            spi_byte(value[8*k +: 8]);
    endtask

    // A well-formed access with random content. Data reads get three or four
    // bytes since the appended status byte depends on the control register;
    // a spare fourth byte is then taken as the next command. Conversion events
    // are slipped in between bytes now and then, as they may arrive at any time.
    task automatic register_transaction(input logic rd, input logic [ADDR_W-1:0] a);
        int n;
        n = int'(reg_size(a));
        if (rd == CMD_RD && a == ADDR_DATA)
            n = 3 + $urandom_range(0, 1);
        transactions++;
        spi_byte({WEN ^ 1'b1, rd, a});
        repeat (n)
        begin
            if ($urandom_range(0, 9) == 0)
                conv_event(24'($urandom), 4'($urandom));
            spi_byte(8'($urandom));
        end
    endtask

    initial
    begin
        logic [ADDR_W-1:0] a;
        int                goal;
        int                pick;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Directed opening. A status read right after reset shows RDY and POR
        // set and clears POR.
        register_transaction(CMD_RD, ADDR_STATUS);
        // Conversion event with every data and channel bit high clears RDY.
        conv_event(24'hFFFFFF, 4'hF);
        // Set the control bit that appends the status byte to data reads.
        write_register(ADDR_CTRL, 24'h000400);
        // Data read with the appended status byte; it sets RDY again.
        spi_byte({WEN ^ 1'b1, CMD_RD, ADDR_DATA});
        repeat (4) spi_byte(8'h00);
        // Conversion event with all bits low.
        conv_event(24'h000000, 4'h0);
        // A write to a read-only register takes its byte but changes nothing.
        write_register(ADDR_ID, 24'h0000AA);
        // An address past the map, then a command with the write-enable bit set.
        spi_byte({WEN ^ 1'b1, CMD_RD, ADDR_END});
        spi_byte({WEN, CMD_WR, ADDR_CTRL});
        // Sixty-four ones restore the defaults and raise POR.
        repeat (8) spi_byte(RESET_BYTE);

        // Random part in three idling regimes: light, heavy, none.
        for (int regime = 0; regime < 3; regime++)
        begin
            idle_pct = (regime == 0) ? 8 : (regime == 1) ? 84 : 0;
            goal     = items_sent + RANDOM_ITEMS / 3;
            while (items_sent < goal)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 62)
                begin
                    // Status, data and control get extra weight for their side effects.
                    case ($urandom_range(0, 5))
                        0:       a = ADDR_STATUS;
                        1:       a = ADDR_DATA;
                        2:       a = ADDR_CTRL;
                        default: a = ADDR_W'($urandom_range(0, ADDR_END - 1));
                    endcase
                    register_transaction(logic'($urandom_range(0, 1)), a);
                end
                else if (pick < 74)
                begin
                    conv_event(24'($urandom), 4'($urandom));
                end
                else if (pick < 80)
                begin
                    // Runs of ones, mostly too short to reset the map.
                    repeat ($urandom_range(1, 8)) spi_byte(RESET_BYTE);
                end
                else
                begin
                    // Noise: any byte, often ignored or a stray command.
                    spi_byte(8'($urandom));
                end
            end
        end

        start <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);

        $display("Run covered %0d items: %0d register accesses and %0d conversion events.",
                 items_sent, transactions, conv_events);
        $display("%0d replies compared; the map was restored by a run of ones %0d times.",
                 replies_checked, restores_seen);
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
